// ----- rtl/pbsa_pkg.sv -----
// shared constants for the page bitmap sub-allocator
// no dependencies; used by page_bitmap_suballocator
`default_nettype none

package pbsa_pkg;

    // parameter defaults
    localparam int PAGES_DEF      = 256;
    localparam int PAGE_BYTES_DEF = 4096;

    // transaction field widths
    localparam int SIZE_W  = 21;
    localparam int ALIGN_W = 5;
    localparam int PIDX_W  = 8;
    localparam int PCNT_W  = 9;
    localparam int OFF_W   = 20;

    // wide enough for handle start plus count and for the largest pool
    localparam int FREE_SUM_W = 11;

    // wide enough for a rounded size before saturation (alignment up to 2^31)
    localparam int ALIGNED_W = 33;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

endpackage

`default_nettype wire

// ----- rtl/pbsa_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module pbsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/page_bitmap_suballocator.sv -----
// first-fit page allocator over one staging pool, used-page bitmap in ram
// depends on pbsa_pkg and pbsa_ram
//
// usage: a transaction is taken when start is high and busy is low. operation
// selects allocate or free; the handle fields describe a held allocation.
// exactly one result comes back per transaction, on the o_ result ports for a
// single cycle while o_done is high; the receiver cannot stall, so the result
// must be captured in that cycle. busy drops in the same cycle as o_done.
//
// sequence: every transaction passes through prep and decide. an allocate served
// inside the held handle, or one that fails before the search, ends at decide. a new
// run scans the bitmap, one page per cycle through the ram read port, then marks
// its pages used one per cycle in the write sweep. a free clears its pages one per
// cycle in the same write sweep. the single bitmap port serves all of these steps.
//
// reset (synchronous, active low) starts a clearing pass that writes every
// page free, one page per cycle: busy stays high until that pass is done.
`default_nettype none

module page_bitmap_suballocator #(
    parameter int PAGES      = pbsa_pkg::PAGES_DEF,
    parameter int PAGE_BYTES = pbsa_pkg::PAGE_BYTES_DEF   // power of two
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_operation,
    input  wire  [pbsa_pkg::SIZE_W-1:0]      i_request_size,
    input  wire  [pbsa_pkg::ALIGN_W-1:0]     i_align_log2,
    input  wire                              i_handle_valid,
    input  wire  [pbsa_pkg::PIDX_W-1:0]      i_handle_page_index,
    input  wire  [pbsa_pkg::PCNT_W-1:0]      i_handle_page_count,
    input  wire  [pbsa_pkg::SIZE_W-1:0]      i_handle_size_left,
    output logic                             o_done,
    output logic                             o_ok,
    output logic [pbsa_pkg::PIDX_W-1:0]      o_out_page_index,
    output logic [pbsa_pkg::PCNT_W-1:0]      o_out_page_count,
    output logic [pbsa_pkg::SIZE_W-1:0]      o_out_size_left,
    output logic [pbsa_pkg::OFF_W-1:0]       o_byte_offset,
    output logic [pbsa_pkg::SIZE_W-1:0]      o_aligned_size
);

    localparam int AW    = $clog2(PAGES);
    localparam int CW    = AW + 1;
    localparam int SHIFT = $clog2(PAGE_BYTES);
    localparam int CAPW  = pbsa_pkg::PCNT_W + SHIFT;
    localparam int BASEW = pbsa_pkg::PIDX_W + SHIFT;
    localparam int AL_W  = pbsa_pkg::ALIGNED_W;
    localparam int FSW   = pbsa_pkg::FREE_SUM_W;
    localparam int NW    = pbsa_pkg::SIZE_W + 1;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;

    localparam logic [CW-1:0] LAST_PAGE = CW'(PAGES - 1);
    localparam logic [CW-1:0] PAGES_C   = CW'(PAGES);

    logic [2:0] r_state, n_state;

    // latched transaction
    logic                           r_op, n_op;
    logic [pbsa_pkg::SIZE_W-1:0]    r_req, n_req;
    logic [pbsa_pkg::ALIGN_W-1:0]   r_alog, n_alog;
    logic                           r_hvalid, n_hvalid;
    logic [pbsa_pkg::PIDX_W-1:0]    r_hidx, n_hidx;
    logic [pbsa_pkg::PCNT_W-1:0]    r_hcnt, n_hcnt;
    logic [pbsa_pkg::SIZE_W-1:0]    r_hleft, n_hleft;

    logic [AL_W-1:0]  r_aligned, n_aligned;
    logic [CAPW-1:0]  r_cap, n_cap;
    logic [BASEW-1:0] r_base, n_base;

    // scan and write sweep
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_end, n_end;
    logic          r_wbit, n_wbit;
    logic [CW-1:0] r_scan, n_scan;
    logic          r_chk_valid, n_chk_valid;
    logic [AW-1:0] r_chk_page, n_chk_page;
    logic [CW-1:0] r_len, n_len;
    logic [AW-1:0] r_start, n_start;
    logic [CW-1:0] r_need, n_need;

    // result registers
    logic                         r_done, n_done;
    logic                         r_ok, n_ok;
    logic [pbsa_pkg::PIDX_W-1:0]  r_pidx, n_pidx;
    logic [pbsa_pkg::PCNT_W-1:0]  r_pcnt, n_pcnt;
    logic [pbsa_pkg::SIZE_W-1:0]  r_left, n_left;
    logic [pbsa_pkg::OFF_W-1:0]   r_off, n_off;
    logic [pbsa_pkg::SIZE_W-1:0]  r_asz, n_asz;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    pbsa_ram #(
        .WIDTH (1),
        .DEPTH (PAGES)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // rounding and handle arithmetic
    logic [AL_W-1:0]                amask;
    logic [pbsa_pkg::SIZE_W-1:0]    aligned21;
    logic                           too_wide;
    logic                           room;
    logic [AL_W-1:0]                bump_off;
    logic [NW-1:0]                  need_full;
    logic [FSW-1:0]                 free_end;
    logic [CW-1:0]                  len_inc;
    logic [AW-1:0]                  run_start;
    logic [31:0]                    start32;
    logic [31:0]                    need32;
    logic [31:0]                    run_bytes;

    always_comb begin
        amask     = (AL_W'(1) << r_alog) - AL_W'(1);
        aligned21 = r_aligned[pbsa_pkg::SIZE_W-1:0];
        too_wide  = |r_aligned[AL_W-1:pbsa_pkg::SIZE_W];
        room      = r_hvalid
                    && (AL_W'(r_hleft) <= AL_W'(r_cap))
                    && (AL_W'(r_hleft) >= r_aligned);
        bump_off  = AL_W'(r_base) + AL_W'(r_cap) - AL_W'(r_hleft);
        need_full = NW'(aligned21 >> SHIFT) + NW'(1);
        free_end  = FSW'(r_hidx) + FSW'(r_hcnt);
        len_inc   = r_len + CW'(1);
        run_start = (r_len == '0) ? r_chk_page : r_start;
        start32   = 32'(r_start);
        need32    = 32'(r_need);
        run_bytes = (need32 << SHIFT) - 32'(aligned21);
    end

    function automatic logic [pbsa_pkg::OFF_W-1:0] OFF_W_SLICE(input logic [31:0] v);
        return v[pbsa_pkg::OFF_W-1:0];
    endfunction

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_req       = r_req;
        n_alog      = r_alog;
        n_hvalid    = r_hvalid;
        n_hidx      = r_hidx;
        n_hcnt      = r_hcnt;
        n_hleft     = r_hleft;
        n_aligned   = r_aligned;
        n_cap       = r_cap;
        n_base      = r_base;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_wbit      = r_wbit;
        n_scan      = r_scan;
        n_chk_valid = 1'b0;
        n_chk_page  = r_chk_page;
        n_len       = r_len;
        n_start     = r_start;
        n_need      = r_need;
        n_done      = 1'b0;
        n_ok        = r_ok;
        n_pidx      = r_pidx;
        n_pcnt      = r_pcnt;
        n_left      = r_left;
        n_off       = r_off;
        n_asz       = r_asz;
        ram_we      = 1'b0;
        ram_waddr   = r_ptr[AW-1:0];
        ram_wdata   = r_wbit;
        ram_raddr   = r_scan[AW-1:0];

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b0;
                n_ptr     = r_ptr + CW'(1);
                if (r_ptr == LAST_PAGE) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_req    = i_request_size;
                    n_alog   = i_align_log2;
                    n_hvalid = i_handle_valid;
                    n_hidx   = i_handle_page_index;
                    n_hcnt   = i_handle_page_count;
                    n_hleft  = i_handle_size_left;
                    n_state  = S_PREP;
                end
            end

            S_PREP: begin
                n_aligned = (AL_W'(r_req) + amask) & ~amask;
                n_cap     = CAPW'(r_hcnt) << SHIFT;
                n_base    = BASEW'(r_hidx) << SHIFT;
                n_state   = S_DECIDE;
            end

            S_DECIDE: begin
                n_ok   = 1'b0;
                n_pidx = '0;
                n_pcnt = '0;
                n_left = '0;
                n_off  = '0;
                n_asz  = '0;
                if (r_op == pbsa_pkg::OP_FREE) begin
                    if (r_hvalid && (r_hcnt != '0) && (FSW'(r_hidx) < FSW'(PAGES))) begin
                        n_ptr   = CW'(r_hidx);
                        n_end   = (free_end > FSW'(PAGES)) ? PAGES_C : CW'(free_end);
                        n_wbit  = 1'b0;
                        n_state = S_WRITE;
                    end else begin
                        n_done  = 1'b1;
                        n_ok    = r_hvalid;
                        n_state = S_IDLE;
                    end
                end else if (too_wide) begin
                    n_done  = 1'b1;
                    n_asz   = pbsa_pkg::SIZE_SAT;
                    n_state = S_IDLE;
                end else if (room) begin
                    // bump allocation inside the held handle
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_pidx  = r_hidx;
                    n_pcnt  = r_hcnt;
                    n_left  = r_hleft - aligned21;
                    n_off   = bump_off[pbsa_pkg::OFF_W-1:0];
                    n_asz   = aligned21;
                    n_state = S_IDLE;
                end else if (need_full > NW'(PAGES)) begin
                    n_done  = 1'b1;
                    n_asz   = aligned21;
                    n_state = S_IDLE;
                end else begin
                    n_need  = CW'(need_full);
                    n_scan  = '0;
                    n_len   = '0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // reads run one page ahead of the run check
                n_chk_valid = (r_scan < PAGES_C);
                n_chk_page  = r_scan[AW-1:0];
                if (r_scan < PAGES_C) begin
                    n_scan = r_scan + CW'(1);
                end
                if (r_chk_valid) begin
                    if (!ram_rdata) begin
                        n_len   = len_inc;
                        n_start = run_start;
                        if (len_inc == r_need) begin
                            n_ptr       = CW'(run_start);
                            n_end       = CW'(run_start) + r_need;
                            n_wbit      = 1'b1;
                            n_chk_valid = 1'b0;
                            n_state     = S_WRITE;
                        end
                    end else begin
                        n_len = '0;
                    end
                    if (!(!ram_rdata && (len_inc == r_need))
                        && (CW'(r_chk_page) == LAST_PAGE)) begin
                        n_done      = 1'b1;
                        n_asz       = aligned21;
                        n_chk_valid = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end

            S_WRITE: begin
                ram_we = 1'b1;
                n_ptr  = r_ptr + CW'(1);
                if (r_ptr + CW'(1) == r_end) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_IDLE;
                    if (r_wbit) begin
                        n_pidx = start32[pbsa_pkg::PIDX_W-1:0];
                        n_pcnt = need32[pbsa_pkg::PCNT_W-1:0];
                        n_left = run_bytes[pbsa_pkg::SIZE_W-1:0];
                        n_off  = OFF_W_SLICE(start32 << SHIFT);
                        n_asz  = aligned21;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_chk_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_chk_valid <= n_chk_valid;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_req      <= n_req;
        r_alog     <= n_alog;
        r_hvalid   <= n_hvalid;
        r_hidx     <= n_hidx;
        r_hcnt     <= n_hcnt;
        r_hleft    <= n_hleft;
        r_aligned  <= n_aligned;
        r_cap      <= n_cap;
        r_base     <= n_base;
        r_end      <= n_end;
        r_wbit     <= n_wbit;
        r_scan     <= n_scan;
        r_chk_page <= n_chk_page;
        r_len      <= n_len;
        r_start    <= n_start;
        r_need     <= n_need;
        r_ok       <= n_ok;
        r_pidx     <= n_pidx;
        r_pcnt     <= n_pcnt;
        r_left     <= n_left;
        r_off      <= n_off;
        r_asz      <= n_asz;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_ok             = r_ok;
    assign o_out_page_index = r_pidx;
    assign o_out_page_count = r_pcnt;
    assign o_out_size_left  = r_left;
    assign o_byte_offset    = r_off;
    assign o_aligned_size   = r_asz;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// testbench for page_bitmap_suballocator: directed and random allocate/free traffic
// checked against a page bitmap kept in the testbench; depends on pbsa_pkg

module tb;

    localparam int PAGES      = pbsa_pkg::PAGES_DEF;
    localparam int PAGE_BYTES = pbsa_pkg::PAGE_BYTES_DEF;
    localparam int SIZE_W     = pbsa_pkg::SIZE_W;
    localparam int ALIGN_W    = pbsa_pkg::ALIGN_W;
    localparam int PIDX_W     = pbsa_pkg::PIDX_W;
    localparam int PCNT_W     = pbsa_pkg::PCNT_W;
    localparam int OFF_W      = pbsa_pkg::OFF_W;
    localparam logic OP_ALLOC = pbsa_pkg::OP_ALLOC;
    localparam logic OP_FREE  = pbsa_pkg::OP_FREE;
    localparam logic [SIZE_W-1:0] SIZE_SAT = pbsa_pkg::SIZE_SAT;
    localparam int CLK_HALF   = 10;

    typedef struct {
        logic               operation;
        logic [SIZE_W-1:0]  request_size;
        logic [ALIGN_W-1:0] align_log2;
        logic               handle_valid;
        logic [PIDX_W-1:0]  handle_page_index;
        logic [PCNT_W-1:0]  handle_page_count;
        logic [SIZE_W-1:0]  handle_size_left;
    } t_pool_request;

    typedef struct {
        logic              ok;
        logic [PIDX_W-1:0] page_index;
        logic [PCNT_W-1:0] page_count;
        logic [SIZE_W-1:0] size_left;
        logic [OFF_W-1:0]  byte_offset;
        logic [SIZE_W-1:0] aligned_size;
    } t_pool_result;

    typedef struct {
        logic [PIDX_W-1:0] page_index;
        logic [PCNT_W-1:0] page_count;
        logic [SIZE_W-1:0] size_left;
    } t_held_handle;

    typedef enum {MIX_NEW, MIX_BUMP, MIX_FREE, MIX_NOISE} t_traffic_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [SIZE_W-1:0]  i_request_size;
    logic [ALIGN_W-1:0] i_align_log2;
    logic               i_handle_valid;
    logic [PIDX_W-1:0]  i_handle_page_index;
    logic [PCNT_W-1:0]  i_handle_page_count;
    logic [SIZE_W-1:0]  i_handle_size_left;
    logic               o_done;
    logic               o_ok;
    logic [PIDX_W-1:0]  o_out_page_index;
    logic [PCNT_W-1:0]  o_out_page_count;
    logic [SIZE_W-1:0]  o_out_size_left;
    logic [OFF_W-1:0]   o_byte_offset;
    logic [SIZE_W-1:0]  o_aligned_size;

    logic [PAGES-1:0]   page_taken;
    t_pool_result       pending_results[$];
    t_held_handle       held_handles[$];
    t_pool_result       oldest_expected;
    int                 mismatch_count = 0;

    page_bitmap_suballocator i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_operation         (i_operation),
        .i_request_size      (i_request_size),
        .i_align_log2        (i_align_log2),
        .i_handle_valid      (i_handle_valid),
        .i_handle_page_index (i_handle_page_index),
        .i_handle_page_count (i_handle_page_count),
        .i_handle_size_left  (i_handle_size_left),
        .o_done              (o_done),
        .o_ok                (o_ok),
        .o_out_page_index    (o_out_page_index),
        .o_out_page_count    (o_out_page_count),
        .o_out_size_left     (o_out_size_left),
        .o_byte_offset       (o_byte_offset),
        .o_aligned_size      (o_aligned_size)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_pool_request make_request(
        input logic               operation,
        input logic [SIZE_W-1:0]  request_size,
        input logic [ALIGN_W-1:0] align_log2,
        input logic               handle_valid,
        input logic [PIDX_W-1:0]  handle_page_index,
        input logic [PCNT_W-1:0]  handle_page_count,
        input logic [SIZE_W-1:0]  handle_size_left
    );
        t_pool_request rq;
        rq.operation         = operation;
        rq.request_size      = request_size;
        rq.align_log2        = align_log2;
        rq.handle_valid      = handle_valid;
        rq.handle_page_index = handle_page_index;
        rq.handle_page_count = handle_page_count;
        rq.handle_size_left  = handle_size_left;
        return rq;
    endfunction

    // first-fit: lowest start of run_len free pages, -1 if there is none
    function automatic int lowest_free_run(input int run_len);
        logic clear;
        if (run_len < 1 || run_len > PAGES)
            return -1;
        for (int s = 0; s + run_len <= PAGES; s++) begin
            clear = 1'b1;
            for (int p = 0; p < run_len; p++)
                if (page_taken[s + p])
                    clear = 1'b0;
            if (clear)
                return s;
        end
        return -1;
    endfunction

    // works out the result of one transaction and updates the page bitmap
    task automatic apply_to_pool(input t_pool_request rq, output t_pool_result rs);
        logic [63:0] round_mask;
        logic [63:0] aligned;
        logic [63:0] capacity;
        logic [63:0] offset;
        logic [63:0] run_bytes;
        int          run_len;
        int          run_start;
        int          free_end;
        rs.ok           = 1'b0;
        rs.page_index   = '0;
        rs.page_count   = '0;
        rs.size_left    = '0;
        rs.byte_offset  = '0;
        rs.aligned_size = '0;
        if (rq.operation == OP_FREE) begin
            rs.ok = rq.handle_valid;
            if (rq.handle_valid) begin
                free_end = int'(rq.handle_page_index) + int'(rq.handle_page_count);
                for (int p = int'(rq.handle_page_index); p < free_end; p++)
                    if (p < PAGES)
                        page_taken[p] = 1'b0;
            end
        end else begin
            round_mask = (64'd1 << rq.align_log2) - 64'd1;
            aligned    = (64'(rq.request_size) + round_mask) & ~round_mask;
            capacity   = 64'(rq.handle_page_count) * 64'(PAGE_BYTES);
            if (aligned > 64'(SIZE_SAT)) begin
                rs.aligned_size = SIZE_SAT;
            end else begin
                rs.aligned_size = aligned[SIZE_W-1:0];
                if (rq.handle_valid && 64'(rq.handle_size_left) <= capacity
                        && 64'(rq.handle_size_left) >= aligned) begin
                    // room left in the held handle: bump inside it
                    offset = 64'(rq.handle_page_index) * 64'(PAGE_BYTES) + capacity
                             - 64'(rq.handle_size_left);
                    rs.ok          = 1'b1;
                    rs.page_index  = rq.handle_page_index;
                    rs.page_count  = rq.handle_page_count;
                    rs.size_left   = rq.handle_size_left - aligned[SIZE_W-1:0];
                    rs.byte_offset = offset[OFF_W-1:0];
                end else begin
                    run_len   = int'(aligned / 64'(PAGE_BYTES)) + 1;
                    run_start = lowest_free_run(run_len);
                    if (run_start >= 0) begin
                        for (int p = run_start; p < run_start + run_len; p++)
                            page_taken[p] = 1'b1;
                        run_bytes      = 64'(run_len) * 64'(PAGE_BYTES) - aligned;
                        offset         = 64'(run_start) * 64'(PAGE_BYTES);
                        rs.ok          = 1'b1;
                        rs.page_index  = run_start[PIDX_W-1:0];
                        rs.page_count  = run_len[PCNT_W-1:0];
                        rs.size_left   = run_bytes[SIZE_W-1:0];
                        rs.byte_offset = offset[OFF_W-1:0];
                    end
                end
            end
        end
    endtask

    // holds start until the block takes the transaction; start is left high
    task automatic send_item(input t_pool_request rq, output t_pool_result rs);
        i_operation         <= rq.operation;
        i_request_size      <= rq.request_size;
        i_align_log2        <= rq.align_log2;
        i_handle_valid      <= rq.handle_valid;
        i_handle_page_index <= rq.handle_page_index;
        i_handle_page_count <= rq.handle_page_count;
        i_handle_size_left  <= rq.handle_size_left;
        start               <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_to_pool(rq, rs);
        pending_results.push_back(rs);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_done)) begin
                flag_mismatch("o_done unknown", 32'hx, 32'd0);
            end else if (o_done) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with nothing pending", 32'd1, 32'd0);
                end else begin
                    oldest_expected = pending_results.pop_front();
                    check_field("ok", 32'(o_ok), 32'(oldest_expected.ok));
                    check_field("page_index", 32'(o_out_page_index),
                                32'(oldest_expected.page_index));
                    check_field("page_count", 32'(o_out_page_count),
                                32'(oldest_expected.page_count));
                    check_field("size_left", 32'(o_out_size_left),
                                32'(oldest_expected.size_left));
                    check_field("byte_offset", 32'(o_byte_offset),
                                32'(oldest_expected.byte_offset));
                    check_field("aligned_size", 32'(o_aligned_size),
                                32'(oldest_expected.aligned_size));
                end
            end
        end
    end

    function automatic logic [SIZE_W-1:0] random_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return SIZE_W'($urandom_range(0, 2 * PAGE_BYTES));
        else if (r < 85)
            return SIZE_W'($urandom_range(0, 16 * PAGE_BYTES));
        else if (r < 97)
            return SIZE_W'($urandom_range(0, 1 << 20));
        return SIZE_W'($urandom());
    endfunction

    function automatic logic [ALIGN_W-1:0] random_align();
        if ($urandom_range(0, 99) < 85)
            return ALIGN_W'($urandom_range(0, 16));
        return ALIGN_W'($urandom_range(0, 31));
    endfunction

    // fresh pool takes a run of every page, then nothing fits until it is freed
    task automatic test_whole_pool();
        t_pool_result whole;
        t_pool_result spare;
        send_item(make_request(OP_ALLOC, 21'd1048575, '0, 1'b0, '0, '0, '0), whole);
        send_item(make_request(OP_ALLOC, '0, '0, 1'b0, '0, '0, '0), spare);
        send_item(make_request(OP_FREE, '0, '0, 1'b1, whole.page_index,
                               whole.page_count, whole.size_left), spare);
        // free without a valid handle leaves the bitmap alone
        send_item(make_request(OP_FREE, '1, '1, 1'b0, '1, '1, '1), spare);
        drain_pending();
    endtask

    task automatic test_size_extremes();
        t_pool_result spare;
        // zero size at the widest alignment still takes a page
        send_item(make_request(OP_ALLOC, '0, 5'd31, 1'b0, '0, '0, '0), spare);
        // run longer than the pool
        send_item(make_request(OP_ALLOC, '1, '0, 1'b0, '1, '1, '1), spare);
        // rounding beyond the size field saturates; 2^20 at 2^16 alignment stays in range
        send_item(make_request(OP_ALLOC, 21'd1, 5'd31, 1'b0, '0, '0, '0), spare);
        send_item(make_request(OP_ALLOC, '1, 5'd1, 1'b0, '0, '0, '0), spare);
        send_item(make_request(OP_ALLOC, 21'd1048576, 5'd16, 1'b0, '0, '0, '0), spare);
        drain_pending();
    endtask

    task automatic test_handle_paths();
        t_pool_result held;
        t_pool_result spare;
        send_item(make_request(OP_ALLOC, 21'd4095, 5'd12, 1'b0, '0, '0, '0), held);
        send_item(make_request(OP_ALLOC, 21'd4097, 5'd4, 1'b0, '0, '0, '0), spare);
        send_item(make_request(OP_ALLOC, 21'd100, 5'd3, 1'b1, held.page_index,
                               held.page_count, held.size_left), held);
        // use up exactly what is left, then a zero-size bump at the very end
        send_item(make_request(OP_ALLOC, held.size_left, '0, 1'b1, held.page_index,
                               held.page_count, held.size_left), held);
        send_item(make_request(OP_ALLOC, '0, '0, 1'b1, held.page_index,
                               held.page_count, held.size_left), spare);
        // no room: a new run is claimed
        send_item(make_request(OP_ALLOC, 21'd1, '0, 1'b1, held.page_index,
                               held.page_count, held.size_left), spare);
        // size left larger than the handle itself
        send_item(make_request(OP_ALLOC, '0, '0, 1'b1, held.page_index, 9'd1,
                               21'd8192), spare);
        send_item(make_request(OP_ALLOC, '0, '0, 1'b1, '1, '0, '0), spare);
        send_item(make_request(OP_ALLOC, '0, '0, 1'b1, '1, '1, '1), spare);
        // free reaching past the end of the pool
        send_item(make_request(OP_FREE, '0, '0, 1'b1, 8'd250, '1, '0), spare);
        send_item(make_request(OP_FREE, '0, '0, 1'b1, '0, 9'd256, '0), spare);
        send_item(make_request(OP_ALLOC, 21'd8192, 5'd13, 1'b0, '0, '0, '0), spare);
        send_item(make_request(OP_FREE, '1, '1, 1'b1, '1, '1, '1), spare);
        drain_pending();
    endtask

    // allocate, bump and free sequences on live handles, with some noise
    task automatic test_random_traffic(input int item_total);
        t_pool_request rq;
        t_pool_result  rs;
        t_held_handle  hh;
        t_traffic_kind kind;
        logic [PCNT_W-1:0] odd_count;
        logic [SIZE_W-1:0] bump_size;
        int sent;
        int burst;
        int gap_max;
        int choice;
        int slot;
        sent = 0;
        while (sent < item_total) begin
            gap_max = ((sent / 200) % 3 == 1) ? 0 : 16;
            burst = int'($urandom_range(1, 20));
            for (int b = 0; b < burst && sent < item_total; b++) begin
                slot = 0;
                choice = int'($urandom_range(0, 99));
                if (held_handles.size() == 0 && choice < 88)
                    kind = MIX_NEW;
                else if (held_handles.size() > 12 && choice < 50)
                    kind = MIX_FREE;
                else if (choice < 35)
                    kind = MIX_NEW;
                else if (choice < 65)
                    kind = MIX_BUMP;
                else if (choice < 88)
                    kind = MIX_FREE;
                else
                    kind = MIX_NOISE;
                if (held_handles.size() != 0) begin
                    slot = int'($urandom_range(0, held_handles.size() - 1));
                    hh = held_handles[slot];
                end
                case (kind)
                    MIX_NEW: begin
                        if ($urandom_range(0, 9) == 0) begin
                            odd_count = PCNT_W'($urandom_range(0, 4));
                            rq = make_request(OP_ALLOC, random_size(), random_align(), 1'b1,
                                              PIDX_W'($urandom()), odd_count,
                                              SIZE_W'(32'(odd_count) * 32'(PAGE_BYTES)
                                                      + $urandom_range(1, PAGE_BYTES)));
                        end else begin
                            rq = make_request(OP_ALLOC, random_size(), random_align(), 1'b0,
                                              PIDX_W'($urandom()), PCNT_W'($urandom()),
                                              SIZE_W'($urandom()));
                        end
                    end
                    MIX_BUMP: begin
                        if ($urandom_range(0, 9) < 6)
                            bump_size = SIZE_W'($urandom_range(0, hh.size_left));
                        else
                            bump_size = random_size();
                        rq = make_request(OP_ALLOC, bump_size,
                                          ALIGN_W'($urandom_range(0, 6)), 1'b1,
                                          hh.page_index, hh.page_count, hh.size_left);
                    end
                    MIX_FREE: begin
                        rq = make_request(OP_FREE, SIZE_W'($urandom()),
                                          ALIGN_W'($urandom()), 1'b1,
                                          hh.page_index, hh.page_count, hh.size_left);
                    end
                    default: begin
                        rq = make_request(1'($urandom()), SIZE_W'($urandom()),
                                          ALIGN_W'($urandom()), 1'($urandom()),
                                          PIDX_W'($urandom()), PCNT_W'($urandom()),
                                          SIZE_W'($urandom()));
                    end
                endcase
                send_item(rq, rs);
                case (kind)
                    MIX_FREE: held_handles.delete(slot);
                    MIX_NEW, MIX_BUMP: begin
                        if (rs.ok) begin
                            if (kind == MIX_BUMP && rs.page_index == hh.page_index
                                    && rs.page_count == hh.page_count)
                                held_handles[slot].size_left = rs.size_left;
                            else
                                held_handles.push_back('{rs.page_index, rs.page_count,
                                                         rs.size_left});
                        end
                    end
                    default: ;
                endcase
                sent++;
            end
            if (gap_max != 0 && $urandom_range(0, 3) != 0)
                idle_for(int'($urandom_range(1, gap_max)));
            if ($urandom_range(0, 63) == 0)
                drain_pending();
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        start               <= 1'b0;
        i_operation         <= OP_ALLOC;
        i_request_size      <= '0;
        i_align_log2        <= '0;
        i_handle_valid      <= 1'b0;
        i_handle_page_index <= '0;
        i_handle_page_count <= '0;
        i_handle_size_left  <= '0;
        page_taken = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_whole_pool();
        test_size_extremes();
        test_handle_paths();
        test_random_traffic(1700);
        drain_pending();
        // a late stray result would show up within a full scan
        repeat (3 * PAGES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
